// ===== design/bft_pkg.sv =====
package bft_pkg;

  // Field widths of one flow endpoint pair
  localparam int ADDR_W = 32;
  localparam int PORT_W = 16;

  // Input beat: opcode, src_addr, src_port, dst_addr, dst_port (104 bits padded)
  localparam int IN_DATA_W  = 104;
  // Result beat: found, entry_index, forward, inserted, full_res (16 bits padded)
  localparam int OUT_DATA_W = 16;
  localparam int IDX_W      = 6;

  // Opcodes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // One stored connection entry
  typedef struct packed {
    logic [PORT_W-1:0] b_port;
    logic [ADDR_W-1:0] b_addr;
    logic [PORT_W-1:0] a_port;
    logic [ADDR_W-1:0] a_addr;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Result of one item
  typedef struct packed {
    logic             full_res;
    logic             inserted;
    logic             forward;
    logic [IDX_W-1:0] entry_index;
    logic             found;
  } result_t;

endpackage

// ===== design/bft_ram.sv =====
module bft_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/bidirectional_flow_table.sv =====
// Bidirectional four-tuple flow table.
// Input channel (in_*): one beat per packet, carrying an opcode (lookup, or
// lookup then insert when absent) and the packet's source and destination
// address and port. Result channel (out_*): exactly one beat per input beat,
// in order, giving found, entry index, forward direction, inserted and full.
// Stored entries are searched from index 0 up through one RAM read port,
// one entry per cycle, and the first entry matching in either direction wins.
// A hit ends the search at the first matching entry; a miss is known once all
// stored entries have passed the registered read port and the compare stage
// behind it, at once when the table is empty. An insert writes the next free
// slot in the cycle the miss is found, so it delays the result no more than a miss.
// One item is in work at a time: the next beat can be accepted from the cycle
// in which the result appears in the output register. If the receiver stalls,
// the result waits in the output register; one more beat is accepted and
// searched, and its result then waits in the block with in_tready low until
// the register frees. Reset empties the table at once (entry count to zero,
// no clearing pass) and drops any pending result.
module bidirectional_flow_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata, lowest bit up: opcode, src_addr, src_port, dst_addr, dst_port
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bft_pkg::IN_DATA_W-1:0]  in_tdata,
  // out_tdata, lowest bit up: found, entry_index, forward, inserted, full_res
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [bft_pkg::OUT_DATA_W-1:0] out_tdata
);

  import bft_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     issue_r, issue_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic              op_r, op_nxt;
  entry_t            key_r, key_nxt;
  result_t           res_r, res_nxt;
  logic              out_vld_r, out_vld_nxt;
  result_t           out_r, out_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  entry_t            ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  logic              in_beat;
  logic              out_free;
  logic              fwd_hit;
  logic              rev_hit;

  bft_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (key_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  assign in_tready  = (state_r == S_IDLE);
  assign in_beat    = in_tvalid && in_tready;
  assign out_free   = !out_vld_r || out_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, out_r};

  // Compare the entry read last cycle in both directions
  assign fwd_hit = (ram_rdata.a_addr == key_r.a_addr) && (ram_rdata.a_port == key_r.a_port) &&
                   (ram_rdata.b_addr == key_r.b_addr) && (ram_rdata.b_port == key_r.b_port);
  assign rev_hit = (ram_rdata.a_addr == key_r.b_addr) && (ram_rdata.a_port == key_r.b_port) &&
                   (ram_rdata.b_addr == key_r.a_addr) && (ram_rdata.b_port == key_r.a_port);

  assign ram_raddr = issue_r[AW-1:0];
  assign ram_waddr = count_r[AW-1:0];

  // Next-state logic
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    issue_nxt   = issue_r;
    cmp_vld_nxt = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    op_nxt      = op_r;
    key_nxt     = key_r;
    res_nxt     = res_r;
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    ram_we      = 1'b0;

    // Output slot drains independently
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          op_nxt         = in_tdata[0];
          key_nxt.a_addr = in_tdata[32:1];
          key_nxt.a_port = in_tdata[48:33];
          key_nxt.b_addr = in_tdata[80:49];
          key_nxt.b_port = in_tdata[96:81];
          issue_nxt      = '0;
          state_nxt      = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (cmp_vld_r && (fwd_hit || rev_hit)) begin
          // First match in index order
          res_nxt             = '0;
          res_nxt.found       = 1'b1;
          res_nxt.entry_index = IDX_W'(cmp_idx_r);
          res_nxt.forward     = fwd_hit;
          state_nxt           = S_DONE;
        end else if (issue_r < count_r) begin
          // Read the next stored entry
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = issue_r[AW-1:0];
          issue_nxt   = issue_r + 1'b1;
        end else if (!cmp_vld_r) begin
          // Search exhausted: miss, optional insert
          res_nxt = '0;
          if (op_r == OP_INSERT) begin
            if (count_r < DEPTH_C) begin
              ram_we              = 1'b1;
              res_nxt.entry_index = IDX_W'(count_r);
              res_nxt.forward     = 1'b1;
              res_nxt.inserted    = 1'b1;
              count_nxt           = count_r + 1'b1;
            end else begin
              res_nxt.full_res = 1'b1;
            end
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          out_nxt     = res_r;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    issue_r   <= issue_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import bft_pkg::*;

  localparam int TABLE_DEPTH  = 64;
  localparam int RAND_ITEMS   = 740;
  localparam int FILL_ITEMS   = 70;
  localparam int QUIET_TAIL   = 150;
  localparam int TAIL_CYCLES  = 80;
  localparam int CYCLE_LIMIT  = 400000;

  // One packet as carried in in_tdata, opcode in bit 0
  typedef struct packed {
    logic [PORT_W-1:0] dst_port;
    logic [ADDR_W-1:0] dst_addr;
    logic [PORT_W-1:0] src_port;
    logic [ADDR_W-1:0] src_addr;
    logic              opcode;
  } pkt_t;

  localparam int PKT_W = $bits(pkt_t);
  localparam int RES_W = $bits(result_t);

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Scoreboard state
  pkt_t        pkt_pend_q [$];
  pkt_t        flow_pool [$];
  result_t     flow_exp_q [$];
  entry_t      flow_tbl [TABLE_DEPTH];
  int unsigned flow_cnt = 0;
  int unsigned total_items = 0;
  int unsigned in_cnt = 0;
  int unsigned out_cnt = 0;
  int unsigned hit_cnt = 0;
  int unsigned ins_cnt = 0;
  int unsigned full_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned in_gap_left = 0;
  int unsigned out_stall_left = 0;
  bit          in_beat_seen = 1'b0;

  bidirectional_flow_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Flow table lookup/insert; updates the shadow table like the block does
  function automatic result_t predict_flow_result(pkt_t p);
    result_t r;
    logic    fwd;
    logic    rev;
    r = '0;
    for (int i = 0; i < flow_cnt; i++) begin
      fwd = flow_tbl[i].a_addr == p.src_addr && flow_tbl[i].a_port == p.src_port &&
            flow_tbl[i].b_addr == p.dst_addr && flow_tbl[i].b_port == p.dst_port;
      rev = flow_tbl[i].a_addr == p.dst_addr && flow_tbl[i].a_port == p.dst_port &&
            flow_tbl[i].b_addr == p.src_addr && flow_tbl[i].b_port == p.src_port;
      if (fwd || rev) begin
        r.found       = 1'b1;
        r.entry_index = IDX_W'(i);
        r.forward     = fwd;
        return r;
      end
    end
    if (p.opcode == OP_INSERT) begin
      if (flow_cnt < TABLE_DEPTH) begin
        flow_tbl[flow_cnt].a_addr = p.src_addr;
        flow_tbl[flow_cnt].a_port = p.src_port;
        flow_tbl[flow_cnt].b_addr = p.dst_addr;
        flow_tbl[flow_cnt].b_port = p.dst_port;
        r.entry_index = IDX_W'(flow_cnt);
        r.forward     = 1'b1;
        r.inserted    = 1'b1;
        flow_cnt++;
      end else begin
        r.full_res = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic pkt_t make_pkt(logic op, logic [ADDR_W-1:0] sa, logic [PORT_W-1:0] sp,
                                    logic [ADDR_W-1:0] da, logic [PORT_W-1:0] dp);
    pkt_t p;
    p.opcode   = op;
    p.src_addr = sa;
    p.src_port = sp;
    p.dst_addr = da;
    p.dst_port = dp;
    return p;
  endfunction

  function automatic pkt_t swap_dir(pkt_t p);
    return make_pkt(p.opcode, p.dst_addr, p.dst_port, p.src_addr, p.src_port);
  endfunction

  function automatic pkt_t rand_pkt(logic op);
    return make_pkt(op, $urandom(), PORT_W'($urandom()), $urandom(), PORT_W'($urandom()));
  endfunction

  function automatic logic rand_op(int unsigned one_in);
    return ($urandom_range(1, one_in) == 1) ? OP_INSERT : OP_LOOKUP;
  endfunction

  // Known flow with one bit or its addresses disturbed (may match if reversed)
  function automatic pkt_t near_miss(pkt_t p);
    pkt_t r;
    r = ($urandom_range(0, 1) == 1) ? swap_dir(p) : p;
    case ($urandom_range(0, 4))
      0: r.src_addr ^= 32'h1 << $urandom_range(0, ADDR_W - 1);
      1: r.src_port ^= 16'h1 << $urandom_range(0, PORT_W - 1);
      2: r.dst_addr ^= 32'h1 << $urandom_range(0, ADDR_W - 1);
      3: r.dst_port ^= 16'h1 << $urandom_range(0, PORT_W - 1);
      default: begin
        // addresses taken from p reversed; on a swapped r this restores a match
        r.src_addr = p.dst_addr;
        r.dst_addr = p.src_addr;
      end
    endcase
    return r;
  endfunction

  task automatic queue_pkt(pkt_t p);
    pkt_pend_q.push_back(p);
    if (p.opcode == OP_INSERT) flow_pool.push_back(p);
  endtask

  function automatic bit gaps_allowed(int unsigned n);
    return ((n / 64) % 3) != 0;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  // Input driver: next beat presented after the previous one was taken
  always @(negedge clk) begin : in_drv
    logic [IN_DATA_W-1:0] word;
    logic                 vld;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_beat_seen) begin
      in_beat_seen = 1'b0;
      vld  = 1'b0;
      word = '0;
      if (in_gap_left > 0) begin
        in_gap_left--;
      end else if (pkt_pend_q.size() > 0) begin
        if (pkt_pend_q.size() > QUIET_TAIL && gaps_allowed(pkt_pend_q.size()) &&
            $urandom_range(0, 3) == 0) begin
          in_gap_left = $urandom_range(0, 2);
        end else begin
          word[PKT_W-1:0] = pkt_pend_q.pop_front();
          vld = 1'b1;
        end
      end
      in_tvalid <= vld;
      in_tdata  <= word;
    end
  end

  // Result receiver backpressure
  always @(negedge clk) begin : out_drv
    logic rdy;
    rdy = 1'b1;
    if (out_stall_left > 0) begin
      out_stall_left--;
      rdy = 1'b0;
    end else if (total_items - out_cnt > QUIET_TAIL && gaps_allowed(out_cnt + 32) &&
                 $urandom_range(0, 3) == 0) begin
      out_stall_left = $urandom_range(0, 2);
      rdy = 1'b0;
    end
    out_tready <= rdy;
  end

  // Beat monitor: predict on input beats, check on result beats
  always @(posedge clk) begin : mon
    result_t got;
    result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        flow_exp_q.push_back(predict_flow_result(pkt_t'(in_tdata[PKT_W-1:0])));
        in_beat_seen = 1'b1;
        in_cnt++;
      end
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[RES_W-1:0]);
        out_cnt++;
        if (flow_exp_q.size() == 0) begin
          $display("%0t: result beat with nothing pending, expected none, actual %h",
                   $time, got);
          fail_cnt++;
        end else begin
          want = flow_exp_q.pop_front();
          hit_cnt  += want.found;
          ins_cnt  += want.inserted;
          full_cnt += want.full_res;
          check_field("found", want.found, got.found);
          check_field("entry_index", want.entry_index, got.entry_index);
          check_field("forward", want.forward, got.forward);
          check_field("inserted", want.inserted, got.inserted);
          check_field("full_res", want.full_res, got.full_res);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stim
    pkt_t        p;
    int unsigned sel;

    // Directed: empty-table miss, extremes, both directions, self flows
    queue_pkt(make_pkt(OP_LOOKUP, '0, '0, '0, '0));
    queue_pkt(make_pkt(OP_INSERT, '0, '0, '0, '0));
    queue_pkt(make_pkt(OP_LOOKUP, '0, '0, '0, '0));
    queue_pkt(make_pkt(OP_INSERT, '1, '1, '1, '1));
    queue_pkt(make_pkt(OP_LOOKUP, '1, '1, '1, '1));
    queue_pkt(make_pkt(OP_INSERT, 32'h0A00_0001, 16'd1234, 32'hC0A8_0001, 16'd80));
    queue_pkt(make_pkt(OP_LOOKUP, 32'hC0A8_0001, 16'd80, 32'h0A00_0001, 16'd1234));
    queue_pkt(make_pkt(OP_INSERT, 32'hC0A8_0001, 16'd80, 32'h0A00_0001, 16'd1234));
    queue_pkt(make_pkt(OP_INSERT, 32'h0A00_0001, 16'd1234, 32'hC0A8_0001, 16'd80));
    queue_pkt(make_pkt(OP_LOOKUP, 32'h0A00_0001, 16'd1234, 32'hC0A8_0001, 16'd81));
    queue_pkt(make_pkt(OP_LOOKUP, 32'hC0A8_0001, 16'd1234, 32'h0A00_0001, 16'd80));
    queue_pkt(make_pkt(OP_INSERT, '1, '0, '0, '1));
    queue_pkt(make_pkt(OP_LOOKUP, '0, '1, '1, '0));
    queue_pkt(make_pkt(OP_INSERT, 32'h7F00_0001, 16'h8000, 32'h7F00_0001, 16'h8000));
    queue_pkt(make_pkt(OP_LOOKUP, 32'h7F00_0001, 16'h8000, 32'h7F00_0001, 16'h8000));
    queue_pkt(make_pkt(OP_LOOKUP, 32'h8000_0000, 16'h0001, 32'h0000_0001, 16'h8000));

    // Random: known flows in either direction, near misses, self flows, new flows
    for (int k = 0; k < RAND_ITEMS; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        p = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
        if ($urandom_range(0, 1) == 1) p = swap_dir(p);
        p.opcode = rand_op(2);
      end else if (sel < 60) begin
        p = near_miss(flow_pool[$urandom_range(0, flow_pool.size() - 1)]);
        p.opcode = rand_op(4);
      end else if (sel < 68) begin
        p = rand_pkt(rand_op(4));
        p.dst_addr = p.src_addr;
        p.dst_port = p.src_port;
      end else begin
        p = rand_pkt(rand_op(4));
      end
      queue_pkt(p);
    end

    // Make sure the table overflows, then replay random earlier insert flows
    for (int k = 0; k < FILL_ITEMS; k++) queue_pkt(rand_pkt(OP_INSERT));
    for (int k = 0; k < 10; k++) begin
      p = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
      if ($urandom_range(0, 1) == 1) p = swap_dir(p);
      p.opcode = rand_op(2);
      queue_pkt(p);
    end
    total_items = pkt_pend_q.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (!(in_cnt == total_items && flow_exp_q.size() == 0)) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d packets, checked %0d results against the shadow flow table.",
             in_cnt, out_cnt);
    $display("Results: %0d matches, %0d new entries, %0d refused with the table full.",
             hit_cnt, ins_cnt, full_cnt);
    if (fail_cnt == 0 && flow_exp_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
